// ===== rtl/vnj_pkg.sv =====
// Package for the 3-vector normalizer with Jacobian.
// Widths, lane numbering and shared types; no dependencies.
`default_nettype none
package vnj_pkg;

  // Width of one input component.
  localparam int INPUT_WIDTH = 16;

  localparam int MW  = INPUT_WIDTH;       // component magnitude, up to 2^(IW-1)
  localparam int SQW = 2*INPUT_WIDTH - 1; // one squared magnitude
  localparam int SW  = 2*INPUT_WIDTH;     // sum of three squares
  localparam int AW  = 2*INPUT_WIDTH;     // Jacobian numerator
  localparam int BW  = 3*SW;              // cube of the squared norm
  localparam int USH = 32;                // unit scale 2^15, squared and doubled
  localparam int JSH = 64;                // Jacobian scale 2^31, squared and doubled
  localparam int DW  = 2*AW + JSH;        // right-hand side of the rounding test
  localparam int QB  = 31;                // quotient bits found per search
  localparam int RW  = BW + 2*QB + 5;     // signed remainder width

  localparam int UW  = 16;                // unit output width
  localparam int JW  = 32;                // Jacobian output width

  localparam int NLANE = 9;
  localparam int NU    = 3;
  localparam int LN_UX = 0;
  localparam int LN_UY = 1;
  localparam int LN_UZ = 2;
  localparam int LN_XX = 3;
  localparam int LN_XY = 4;
  localparam int LN_XZ = 5;
  localparam int LN_YY = 6;
  localparam int LN_YZ = 7;
  localparam int LN_ZZ = 8;

  localparam int FST = 6;             // front-end stages
  localparam int NST = FST + QB + 1;  // all stages, output register included

  typedef logic [BW-1:0] base_t;
  typedef logic [DW-1:0] rhs_t;
  typedef logic [QB-1:0] quo_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } meta_t;

endpackage
`default_nettype wire

// ===== rtl/vnj_in_if.sv =====
// Input channel of the normalizer: valid/ready and one vector per beat.
// Depends on vnj_pkg.
`default_nettype none
interface vnj_in_if import vnj_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [INPUT_WIDTH-1:0] vec_x;
  logic signed [INPUT_WIDTH-1:0] vec_y;
  logic signed [INPUT_WIDTH-1:0] vec_z;
  modport source(output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink(input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/vnj_out_if.sv =====
// Result channel of the normalizer: unit vector, Jacobian entries, zero flag.
// Depends on vnj_pkg.
`default_nettype none
interface vnj_out_if import vnj_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [UW-1:0] unit_x;
  logic signed [UW-1:0] unit_y;
  logic signed [UW-1:0] unit_z;
  logic signed [JW-1:0] jac_xx;
  logic signed [JW-1:0] jac_xy;
  logic signed [JW-1:0] jac_xz;
  logic signed [JW-1:0] jac_yy;
  logic signed [JW-1:0] jac_yz;
  logic signed [JW-1:0] jac_zz;
  logic                 zero_vector;
  modport source(output valid, output unit_x, output unit_y, output unit_z,
                 output jac_xx, output jac_xy, output jac_xz, output jac_yy,
                 output jac_yz, output jac_zz, output zero_vector, input ready);
  modport sink(input valid, input unit_x, input unit_y, input unit_z,
               input jac_xx, input jac_xy, input jac_xz, input jac_yy,
               input jac_yz, input jac_zz, input zero_vector, output ready);
endinterface
`default_nettype wire

// ===== rtl/vector3_normalize_with_jacobian_top.sv =====
// Path: an accepted input beat passes 6 front-end stages, 31 search stages and
// 1 output register before its result beat.
// Throughput: one vector per cycle while the output accepts; every stage holds
// its own valid bit, so a stalled output stops only the stages that are full behind it.
// Reset: synchronous, active low on rst_n; it clears all stage valid bits.
// Depends on vnj_pkg, vnj_in_if, vnj_out_if, vnj_front, vnj_lane and vnj_merge.
`default_nettype none
module vector3_normalize_with_jacobian_top import vnj_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  vnj_in_if.sink    in_ch,
  vnj_out_if.source out_ch
);

  // Stage control. A stage advances when it is empty or when the stage after
  // it advances; the last stage is the output register.
  logic [NST-1:0] valid_r, valid_nxt, adv;

  always_comb begin
    adv[NST-1] = !valid_r[NST-1] || out_ch.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
    valid_nxt[0] = adv[0] ? in_ch.valid : valid_r[0];
    for (int i = 1; i < NST; i++) begin
      valid_nxt[i] = adv[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ch.ready  = adv[0];
  assign out_ch.valid = valid_r[NST-1];

  // Front end: the norm cube and one pair of search operands per lane.
  base_t base_u, base_j;
  rhs_t  rhs [NLANE];
  meta_t meta_f;

  vnj_front u_front (
    .clk    (clk),
    .adv    (adv[FST-1:0]),
    .vec_x  (in_ch.vec_x),
    .vec_y  (in_ch.vec_y),
    .vec_z  (in_ch.vec_z),
    .base_u (base_u),
    .base_j (base_j),
    .rhs    (rhs),
    .meta   (meta_f)
  );

  // Nine lanes in lockstep: three unit components use the squared norm,
  // six Jacobian entries use its cube.
  quo_t q [NLANE];

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    if (l < NU) begin : g_unit
      vnj_lane u_lane (
        .clk  (clk),
        .adv  (adv[FST+QB-1:FST]),
        .base (base_u),
        .rhs  (rhs[l]),
        .q    (q[l])
      );
    end else begin : g_jac
      vnj_lane u_lane (
        .clk  (clk),
        .adv  (adv[FST+QB-1:FST]),
        .base (base_j),
        .rhs  (rhs[l]),
        .q    (q[l])
      );
    end
  end

  // Signs and the zero flag ride alongside the search stages.
  meta_t meta_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_meta
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv[FST]) begin
          meta_r[0] <= meta_f;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv[FST+k]) begin
          meta_r[k] <= meta_r[k-1];
        end
      end
    end
  end

  logic signed [UW-1:0] unit [NU];
  logic signed [JW-1:0] jac [NLANE-NU];
  logic                 zero_r;

  vnj_merge u_merge (
    .clk  (clk),
    .adv  (adv[NST-1]),
    .q    (q),
    .meta (meta_r[QB-1]),
    .unit (unit),
    .jac  (jac)
  );

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      zero_r <= meta_r[QB-1].zero;
    end
  end

  assign out_ch.unit_x      = unit[LN_UX];
  assign out_ch.unit_y      = unit[LN_UY];
  assign out_ch.unit_z      = unit[LN_UZ];
  assign out_ch.jac_xx      = jac[LN_XX-NU];
  assign out_ch.jac_xy      = jac[LN_XY-NU];
  assign out_ch.jac_xz      = jac[LN_XZ-NU];
  assign out_ch.jac_yy      = jac[LN_YY-NU];
  assign out_ch.jac_yz      = jac[LN_YZ-NU];
  assign out_ch.jac_zz      = jac[LN_ZZ-NU];
  assign out_ch.zero_vector = zero_r;

  // The input side can only stall when every stage holds a vector.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> &valid_r)
    else $error("input stalled while a stage was empty");

  // A zero vector gives zero results; checked on the unit components and on jac_xx, jac_xy, jac_yz.
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_vector |->
      out_ch.unit_x == '0 && out_ch.unit_y == '0 && out_ch.unit_z == '0 &&
      out_ch.jac_xx == '0 && out_ch.jac_xy == '0 && out_ch.jac_yz == '0)
    else $error("zero vector with nonzero result");

  // Diagonal Jacobian entries are never negative.
  a_diag_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !out_ch.jac_xx[JW-1] && !out_ch.jac_yy[JW-1] && !out_ch.jac_zz[JW-1])
    else $error("negative diagonal Jacobian entry");

  // A held result stays valid and keeps its zero flag while the output stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(zero_r) && out_ch.valid)
    else $error("output register changed under stall");

endmodule
`default_nettype wire

// ===== rtl/vnj_front.sv =====
// Front end: magnitudes, squares, norm cube and the per-lane search operands.
// Six registered stages; depends on vnj_pkg.
`default_nettype none
module vnj_front import vnj_pkg::*; (
  input  logic                          clk,
  input  logic [FST-1:0]                adv,
  input  logic signed [INPUT_WIDTH-1:0] vec_x,
  input  logic signed [INPUT_WIDTH-1:0] vec_y,
  input  logic signed [INPUT_WIDTH-1:0] vec_z,
  output base_t                         base_u,
  output base_t                         base_j,
  output rhs_t                          rhs [NLANE],
  output meta_t                         meta
);

  logic [INPUT_WIDTH-1:0] raw [3];
  logic [MW-1:0]  m_r [3];
  logic [2:0]     n0_r, n1_r, n2_r, n3_r, n4_r;
  logic [SQW-1:0] sq_r [3];
  logic [AW-1:0]  cr_r [3];
  logic [SW-1:0]  s_r;
  logic [AW-1:0]  a_r [6];
  logic [SQW-1:0] usq2_r [3];
  logic [SQW-1:0] usq3_r [3];
  logic [SQW-1:0] usq4_r [3];
  logic [2*SW-1:0] s2_r;
  logic [2*AW-1:0] asq_r [6];
  logic [2*AW-1:0] asq4_r [6];
  logic [SW-1:0]   s3c_r, s4c_r;
  logic            z3_r, z4_r;
  logic [2*SW-1:0] plo_r, phi_r;
  base_t           base_u_r, base_j_r;
  rhs_t            rhs_r [NLANE];
  meta_t           meta_r;

  assign raw[0] = vec_x;
  assign raw[1] = vec_y;
  assign raw[2] = vec_z;

  // Sign and magnitude; the most negative value becomes 2^(IW-1).
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        n0_r[i] <= raw[i][INPUT_WIDTH-1];
        m_r[i]  <= raw[i][INPUT_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQW'(m_r[i] * m_r[i]);
      end
      cr_r[0] <= m_r[0] * m_r[1];
      cr_r[1] <= m_r[0] * m_r[2];
      cr_r[2] <= m_r[1] * m_r[2];
      n1_r    <= n0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      a_r[LN_XX-NU] <= AW'(sq_r[1]) + AW'(sq_r[2]);
      a_r[LN_XY-NU] <= cr_r[0];
      a_r[LN_XZ-NU] <= cr_r[1];
      a_r[LN_YY-NU] <= AW'(sq_r[0]) + AW'(sq_r[2]);
      a_r[LN_YZ-NU] <= cr_r[2];
      a_r[LN_ZZ-NU] <= AW'(sq_r[0]) + AW'(sq_r[1]);
      usq2_r <= sq_r;
      n2_r   <= n1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s2_r  <= s_r * s_r;
      for (int j = 0; j < 6; j++) begin
        asq_r[j] <= a_r[j] * a_r[j];
      end
      s3c_r  <= s_r;
      z3_r   <= (s_r == '0);
      usq3_r <= usq2_r;
      n3_r   <= n2_r;
    end
  end

  // The cube is S^2 times S, split into two partial products.
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      plo_r  <= s2_r[SW-1:0] * s3c_r;
      phi_r  <= s2_r[2*SW-1:SW] * s3c_r;
      s4c_r  <= s3c_r;
      asq4_r <= asq_r;
      usq4_r <= usq3_r;
      z4_r   <= z3_r;
      n4_r   <= n3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      base_j_r <= BW'(plo_r) + {phi_r, {SW{1'b0}}};
      base_u_r <= BW'(s4c_r);
      for (int i = 0; i < NU; i++) begin
        rhs_r[i] <= DW'({usq4_r[i], {USH{1'b0}}});
      end
      for (int j = 0; j < 6; j++) begin
        rhs_r[NU+j] <= {asq4_r[j], {JSH{1'b0}}};
      end
      meta_r.neg  <= n4_r;
      meta_r.zero <= z4_r;
    end
  end

  assign base_u = base_u_r;
  assign base_j = base_j_r;
  assign rhs    = rhs_r;
  assign meta   = meta_r;

endmodule
`default_nettype wire

// ===== rtl/vnj_lane.sv =====
// One search lane: finds the largest q with (2q-1)^2 * base <= rhs, one bit a stage.
// The remainder and the product d*base are updated with shifts and adds only.
// Depends on vnj_pkg.
`default_nettype none
module vnj_lane import vnj_pkg::*; (
  input  logic          clk,
  input  logic [QB-1:0] adv,
  input  base_t         base,
  input  rhs_t          rhs,
  output quo_t          q
);

  logic signed [RW-1:0] rm_r [QB-1];
  logic signed [RW-1:0] p_r  [QB-1];
  base_t                b_r  [QB-1];
  quo_t                 q_r  [QB];

  logic signed [RW-1:0] rm_init, p_init;

  // Start from q = 0, that is d = -1: remainder rhs - base, product -base.
  assign rm_init = $signed(RW'(rhs)) - $signed(RW'(base));
  assign p_init  = -$signed(RW'(base));

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BIT = QB - 1 - k;
    logic signed [RW-1:0] rm_s, p_s, bx, cand, diff;
    base_t                bs;
    quo_t                 qs;
    logic                 take;

    if (k == 0) begin : g_first
      assign rm_s = rm_init;
      assign p_s  = p_init;
      assign bs   = base;
      assign qs   = '0;
    end else begin : g_next
      assign rm_s = rm_r[k-1];
      assign p_s  = p_r[k-1];
      assign bs   = b_r[k-1];
      assign qs   = q_r[k-1];
    end

    // Setting this bit raises d by 2^(BIT+1); the square grows by
    // base * (2^(BIT+2) * d + 2^(2*BIT+2)).
    assign bx   = $signed(RW'(bs));
    assign cand = (p_s <<< (BIT + 2)) + (bx <<< (2*BIT + 2));
    assign diff = rm_s - cand;
    assign take = ~diff[RW-1];

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        q_r[k] <= take ? (qs | (QB'(1) << BIT)) : qs;
      end
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          rm_r[k] <= take ? diff : rm_s;
          p_r[k]  <= take ? (p_s + (bx <<< (BIT + 1))) : p_s;
          b_r[k]  <= bs;
        end
      end
    end
  end

  assign q = q_r[QB-1];

endmodule
`default_nettype wire

// ===== rtl/vnj_merge.sv =====
// Merge stage: applies signs, saturation and the zero-vector rule to the lane
// results and holds them in the output register. Depends on vnj_pkg.
`default_nettype none
module vnj_merge import vnj_pkg::*; (
  input  logic                 clk,
  input  logic                 adv,
  input  quo_t                 q [NLANE],
  input  meta_t                meta,
  output logic signed [UW-1:0] unit [NU],
  output logic signed [JW-1:0] jac [NLANE-NU]
);

  localparam quo_t UPOS = quo_t'((1 << (UW-1)) - 1);
  localparam quo_t UNEG = quo_t'(1 << (UW-1));

  logic signed [UW-1:0] unit_nxt [NU];
  logic signed [JW-1:0] jac_nxt [NLANE-NU];
  logic [UW-1:0]        umag [NU];
  logic [JW-1:0]        jmag [NLANE-NU];
  logic [NLANE-NU-1:0]  jneg;

  // Off-diagonal entries are negative when both components share a sign.
  assign jneg[LN_XX-NU] = 1'b0;
  assign jneg[LN_XY-NU] = (meta.neg[0] == meta.neg[1]);
  assign jneg[LN_XZ-NU] = (meta.neg[0] == meta.neg[2]);
  assign jneg[LN_YY-NU] = 1'b0;
  assign jneg[LN_YZ-NU] = (meta.neg[1] == meta.neg[2]);
  assign jneg[LN_ZZ-NU] = 1'b0;

  always_comb begin
    for (int i = 0; i < NU; i++) begin
      if (meta.neg[i]) begin
        umag[i] = (q[i] > UNEG) ? UNEG[UW-1:0] : q[i][UW-1:0];
        unit_nxt[i] = -$signed(umag[i]);
      end else begin
        umag[i] = (q[i] > UPOS) ? UPOS[UW-1:0] : q[i][UW-1:0];
        unit_nxt[i] = $signed(umag[i]);
      end
      if (meta.zero) begin
        unit_nxt[i] = '0;
      end
    end
    for (int j = 0; j < NLANE - NU; j++) begin
      jmag[j]    = JW'(q[NU+j]);
      jac_nxt[j] = jneg[j] ? -$signed(jmag[j]) : $signed(jmag[j]);
      if (meta.zero) begin
        jac_nxt[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit <= unit_nxt;
      jac  <= jac_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_vector3_normalize_with_jacobian_top.sv =====
// Testbench for the 3-vector normalizer with Jacobian: directed table, then random vectors.
// Each result beat is checked against a typed-in expectation or an exact integer predictor;
// depends on vnj_pkg and the vnj_in_if / vnj_out_if channel interfaces.
`default_nettype none
module tb_vector3_normalize_with_jacobian_top;
  import vnj_pkg::*;

  localparam int N_RANDOM   = 1880;
  localparam int CYCLE_CAP  = 300000;
  localparam int DRAIN_WAIT = 60;   // a little over the pipeline latency

  // One result beat as the block should present it.
  typedef struct packed {
    logic signed [UW-1:0] ux, uy, uz;
    logic signed [JW-1:0] xx, xy, xz, yy, yz, zz;
    logic                 zero;
  } norm_res_t;

  // One row of the directed table. When has_known is set, the expected result
  // is typed in the row; otherwise the predictor supplies it.
  typedef struct {
    logic signed [INPUT_WIDTH-1:0] x, y, z;
    bit                            has_known;
    norm_res_t                     known;
  } vec_row_t;

  logic clk;
  logic rst_n;
  int   cycles;
  int   errors;
  bit   calm;      // when set, neither side idles

  norm_res_t pending_q[$];

  vnj_in_if  in_ch();
  vnj_out_if out_ch();

  vector3_normalize_with_jacobian_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 20-unit clock period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Largest q below 2^bits with (2q-1)^2 * base <= rhs. This picks the value
  // rounded to nearest, ties away from zero, without any division.
  function automatic logic [255:0] round_nearest(logic [255:0] base, logic [255:0] rhs,
                                                 int bits);
    logic [255:0] q, t, d;
    q = '0;
    for (int b = bits - 1; b >= 0; b--) begin
      t = q | (256'd1 << b);
      d = 2 * t - 1;
      if (d * d * base <= rhs) q = t;
    end
    return q;
  endfunction

  // Jacobian magnitude round(a * 2^31 / S^(3/2)), at most 2^31 - 1 by construction.
  function automatic logic [JW-1:0] jac_mag(logic [255:0] a, logic [255:0] s3);
    return JW'(round_nearest(s3, (a * a) << 64, 31));
  endfunction

  function automatic logic [JW-1:0] apply_sign(logic [JW-1:0] mag, bit neg);
    return neg ? -mag : mag;
  endfunction

  // Expected unit vector and Jacobian for one input vector.
  function automatic norm_res_t normalize_vec(logic signed [INPUT_WIDTH-1:0] x,
                                              logic signed [INPUT_WIDTH-1:0] y,
                                              logic signed [INPUT_WIDTH-1:0] z);
    logic [INPUT_WIDTH-1:0] comp [3];
    logic [255:0] mag [3];
    logic [255:0] sq [3];
    logic [255:0] s, s3, q;
    bit           neg [3];
    logic [UW-1:0] unit [3];
    norm_res_t    r;
    comp[0] = x;
    comp[1] = y;
    comp[2] = z;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][INPUT_WIDTH-1];
      mag[i] = neg[i] ? (256'd1 << INPUT_WIDTH) - comp[i] : 256'(comp[i]);
      sq[i]  = mag[i] * mag[i];
    end
    s = sq[0] + sq[1] + sq[2];
    if (s == 0) begin
      r.zero = 1'b1;
      return r;
    end
    s3 = s * s * s;
    for (int i = 0; i < 3; i++) begin
      q = round_nearest(s, sq[i] << 32, 16);
      // +1 cannot be shown in Q1.15, so it clips; -1 is kept.
      if (!neg[i] && q > 32767) q = 32767;
      if (neg[i] && q > 32768) q = 32768;
      unit[i] = neg[i] ? -UW'(q) : UW'(q);
    end
    r.ux = unit[0];
    r.uy = unit[1];
    r.uz = unit[2];
    // Off-diagonal entries are -ci*cj/n^3: negative when the signs agree.
    r.xx = jac_mag(sq[1] + sq[2], s3);
    r.yy = jac_mag(sq[0] + sq[2], s3);
    r.zz = jac_mag(sq[0] + sq[1], s3);
    r.xy = apply_sign(jac_mag(mag[0] * mag[1], s3), neg[0] == neg[1]);
    r.xz = apply_sign(jac_mag(mag[0] * mag[2], s3), neg[0] == neg[2]);
    r.yz = apply_sign(jac_mag(mag[1] * mag[2], s3), neg[1] == neg[2]);
    return r;
  endfunction

  task automatic cmp_field(string name, longint want, longint got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver stalls with a chance of about 26 in a hundred, except in the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 26);
  end

  // Each result beat is checked against the oldest pending expectation.
  always @(posedge clk) begin
    norm_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result beat arrived with no vector outstanding");
        errors++;
      end else begin
        e = pending_q.pop_front();
        cmp_field("unit_x", e.ux, out_ch.unit_x);
        cmp_field("unit_y", e.uy, out_ch.unit_y);
        cmp_field("unit_z", e.uz, out_ch.unit_z);
        cmp_field("jac_xx", e.xx, out_ch.jac_xx);
        cmp_field("jac_xy", e.xy, out_ch.jac_xy);
        cmp_field("jac_xz", e.xz, out_ch.jac_xz);
        cmp_field("jac_yy", e.yy, out_ch.jac_yy);
        cmp_field("jac_yz", e.yz, out_ch.jac_yz);
        cmp_field("jac_zz", e.zz, out_ch.jac_zz);
        cmp_field("zero_vector", e.zero, out_ch.zero_vector);
      end
    end
  end

  // Present one vector and hold it until the block takes it. The beat stays
  // valid across back-to-back vectors; a short random gap comes before some of them.
  task automatic send_vec(logic signed [INPUT_WIDTH-1:0] x, logic signed [INPUT_WIDTH-1:0] y,
                          logic signed [INPUT_WIDTH-1:0] z, norm_res_t want);
    if (!calm && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vec_x <= x;
    in_ch.vec_y <= y;
    in_ch.vec_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(want);
  endtask

  function automatic logic signed [INPUT_WIDTH-1:0] rand_comp(int shape);
    case (shape)
      0: return INPUT_WIDTH'($signed($urandom_range(6)) - 3);  // tiny, exact ties likely
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;     // extremes
      2: return '0;
      default: return INPUT_WIDTH'($urandom);
    endcase
  endfunction

  function automatic vec_row_t plain_row(int x, int y, int z);
    vec_row_t r;
    r.x = INPUT_WIDTH'(x);
    r.y = INPUT_WIDTH'(y);
    r.z = INPUT_WIDTH'(z);
    r.has_known = 1'b0;
    r.known = '0;
    return r;
  endfunction

  function automatic vec_row_t known_row(int x, int y, int z, norm_res_t k);
    vec_row_t r;
    r = plain_row(x, y, z);
    r.has_known = 1'b1;
    r.known = k;
    return r;
  endfunction

  initial begin
    vec_row_t  table_rows[$];
    norm_res_t k;
    logic signed [INPUT_WIDTH-1:0] x, y, z;
    int wait_cycles;

    cycles = 0;
    errors = 0;
    calm   = 1'b0;
    rst_n  = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.vec_x  = '0;
    in_ch.vec_y  = '0;
    in_ch.vec_z  = '0;
    out_ch.ready = 1'b0;

    // The zero vector raises the flag and clears every other field.
    k = '0;
    k.zero = 1'b1;
    table_rows.push_back(known_row(0, 0, 0, k));
    // A unit-length axis: +1 clips to 32767 and the other diagonals saturate.
    k = '0;
    k.ux = UW'(32767);
    k.yy = 32'h7FFF_FFFF;
    k.zz = 32'h7FFF_FFFF;
    table_rows.push_back(known_row(1, 0, 0, k));
    // -1 along y is kept as -32768.
    k = '0;
    k.uy = UW'(-32768);
    k.xx = 32'h7FFF_FFFF;
    k.zz = 32'h7FFF_FFFF;
    table_rows.push_back(known_row(0, -1, 0, k));
    // Most negative input: n = 2^15, so the off-axis diagonals are 2^16.
    k = '0;
    k.uz = UW'(-32768);
    k.xx = 65536;
    k.yy = 65536;
    table_rows.push_back(known_row(0, 0, -32768, k));
    table_rows.push_back(plain_row(32767, 32767, 32767));
    table_rows.push_back(plain_row(-32768, -32768, -32768));
    table_rows.push_back(plain_row(32767, -32768, 0));
    table_rows.push_back(plain_row(-32768, 32767, -1));
    table_rows.push_back(plain_row(1, 1, 1));
    table_rows.push_back(plain_row(-1, 1, -1));
    table_rows.push_back(plain_row(3, 4, 0));     // integer norm
    table_rows.push_back(plain_row(2, -3, 6));    // integer norm, mixed signs
    table_rows.push_back(plain_row(0, 5, -12));
    table_rows.push_back(plain_row(1, 2, 2));
    table_rows.push_back(plain_row(32767, 1, 0));
    table_rows.push_back(plain_row(1, 0, 1));
    table_rows.push_back(plain_row(-21846, 10923, 32767));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      send_vec(table_rows[i].x, table_rows[i].y, table_rows[i].z,
               table_rows[i].has_known ? table_rows[i].known :
               normalize_vec(table_rows[i].x, table_rows[i].y, table_rows[i].z));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // One stretch runs with neither side idling.
      calm = (n >= 600 && n < 900);
      // Let the pipeline empty completely once, mid-run.
      if (n == 1200) begin
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 60) begin
        x = INPUT_WIDTH'($urandom);
        y = INPUT_WIDTH'($urandom);
        z = INPUT_WIDTH'($urandom);
      end else begin
        x = rand_comp($urandom_range(4));
        y = rand_comp($urandom_range(4));
        z = rand_comp($urandom_range(4));
      end
      send_vec(x, y, z, normalize_vec(x, y, z));
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    // Any stray beat would show up within the pipeline latency.
    wait_cycles = DRAIN_WAIT;
    repeat (wait_cycles) @(posedge clk);

    if (errors == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
